[rtl/cfaf_pkg.sv]
// Shared constants and saturation and magnitude helpers for the circular field avoidance block.
package cfaf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WIDE_W        = 82;

    localparam logic signed [WIDE_W-1:0] S32_MAX = 82'sd2147483647;
    localparam logic signed [WIDE_W-1:0] S32_MIN = -82'sd2147483648;
    localparam logic signed [WIDE_W-1:0] S48_MAX = 82'sd140737488355327;
    localparam logic signed [WIDE_W-1:0] S48_MIN = -82'sd140737488355328;

    // Clamp a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = 32'sh7FFFFFFF;
        else if (v < S32_MIN)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Clamp a wide signed value to 48 bits.
    function automatic logic signed [47:0] sat48(input logic signed [WIDE_W-1:0] v);
        logic signed [47:0] r;
        if (v > S48_MAX)
            r = 48'sh7FFFFFFFFFFF;
        else if (v < S48_MIN)
            r = 48'sh800000000000;
        else
            r = v[47:0];
        return r;
    endfunction

    // Magnitude of a 32-bit signed value, as unsigned.
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

[rtl/circular_field_avoid_force.sv]
// Top level of the circular field obstacle avoidance force block.
//
// One obstacle transaction enters on the s_ side when s_tready is high; the block then
// works on it alone and drops s_tready until the result is placed in the output register.
// All arithmetic runs through one shared 32x32 unsigned multiplier (sign handled aside)
// and one restoring divider that produces one quotient bit per cycle. A contributing obstacle
// runs through the accept step, eight multiplies for the squares, the dot product and the
// distance limits, a decision step, three divisions, five multiplies and an accumulate step
// for the force terms, and a step that loads the output register. An obstacle that adds
// nothing (invalid, outside its influence distance, zero distance or zero velocity) skips
// the divisions and force terms. A transaction marked last adds the gain multiply, done as
// two 24-bit halves per axis. The result waits in the output register and the next
// obstacle may be accepted meanwhile; a result that finds the output register still full
// holds the block in its load cycle until the register drains.
// Values are fixed point with FRAC_BITS fraction bits and saturate at every step; the
// 48-bit running sum is cleared when the last result is loaded. force_gain lives at byte
// address 0 of the APB port and resets to 1.0.
module circular_field_avoid_force
#(
    parameter int FRAC_BITS = cfaf_pkg::FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vec_x[31:0], vec_y[63:32], vel_x[95:64], vel_y[127:96], influence_dist[158:128],
    // critical_dist[189:159], weight[220:190], target_x[252:221], target_y[284:253], zero
    input  logic [287:0] s_tdata,
    // obstacle_valid
    input  logic         s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // crit_x[31:0], crit_y[63:32], force_x[95:64], force_y[127:96]
    output logic [127:0] m_tdata,
    // is_critical
    output logic         m_tuser,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import cfaf_pkg::*;

    localparam int NW = 63 + FRAC_BITS;
    localparam longint WMIN_L = (longint'(1) << FRAC_BITS) / 100000;
    localparam logic [30:0] WMIN = 31'(WMIN_L);
    localparam logic [30:0] GAIN_RST = 31'(longint'(1) << FRAC_BITS);

    typedef enum logic [4:0] {
        S_IDLE, S_DD0, S_DD1, S_VV0, S_VV1, S_P1, S_P2, S_IN2, S_CR2, S_DEC,
        S_DLD, S_DCHK, S_DRUN, S_DEND, S_H, S_T1, S_T2, S_F1, S_F2, S_ACC,
        S_G0, S_G1, S_G2, S_G3, S_G4, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_S, DIV_G, DIV_K
    } div_sel_t;

    state_t   state_reg;
    div_sel_t sel_reg;
    logic [4:0] cnt_reg;
    logic       ov_reg;
    logic [127:0] odata_reg;
    logic       ouser_reg;
    logic       olast_reg;
    logic signed [47:0] sum_x_reg;
    logic signed [47:0] sum_y_reg;
    logic [30:0] gain_reg;

    // Captured transaction
    logic signed [31:0] dx_reg, dy_reg, vx_reg, vy_reg, tx_reg, ty_reg;
    logic [30:0] infl_reg, crit_reg, w_reg;
    logic        valid_reg, last_reg;

    // Datapath
    logic [63:0] prod_reg;
    logic        pneg_reg;
    logic [63:0] dd_reg, vv_reg;
    logic signed [WIDE_W-1:0] p1_reg;
    logic [62:0] dm_reg;
    logic        dneg_reg;
    logic        inside_reg, critical_reg;
    logic [NW-32:0] dhi_reg;
    logic [30:0] nlo_reg;
    logic [63:0] den_reg, rem_reg;
    logic [30:0] quo_reg;
    logic        dsat_reg;
    logic signed [31:0] s_reg, g_reg, k_reg, h_reg, ex_reg, ey_reg;
    logic [63:0] gh_reg;
    logic signed [31:0] fx_reg, fy_reg;

    logic [31:0] mul_a, mul_b;
    logic        mul_neg;
    logic signed [WIDE_W-1:0] pval, psh, dsum, gsig;
    logic [63:0] pshm;
    logic [87:0] gtot;
    logic [47:0] smag_x, smag_y;
    logic [NW-1:0] num;
    logic [64:0] rem2;
    logic        rem_ge;
    logic        dsign;
    logic signed [31:0] dres;
    logic        contrib;
    logic        cfg_wr;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;
    assign m_tlast  = olast_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {1'b0, gain_reg} : 32'd0;
    assign cfg_wr   = psel & penable & pwrite & ~paddr[2];

    // Signed views of the registered product
    assign pval = pneg_reg ? -$signed({18'd0, prod_reg}) : $signed({18'd0, prod_reg});
    assign pshm = prod_reg >> FRAC_BITS;
    assign psh  = pneg_reg ? -$signed({18'd0, pshm}) : $signed({18'd0, pshm});
    assign dsum = p1_reg + pval;
    assign gtot = ({gh_reg, 24'd0} + 88'(prod_reg)) >> FRAC_BITS;
    assign gsig = pneg_reg ? -$signed({1'b0, 81'(gtot)}) : $signed({1'b0, 81'(gtot)});
    assign smag_x = sum_x_reg[47] ? 48'(-sum_x_reg) : 48'(sum_x_reg);
    assign smag_y = sum_y_reg[47] ? 48'(-sum_y_reg) : 48'(sum_y_reg);

    assign contrib = inside_reg && (dd_reg != 64'd0) && (vv_reg != 64'd0);

    // Divider operands and one restoring step
    assign num = (sel_reg == DIV_K) ? (NW'(mag32(g_reg)) << (2 * FRAC_BITS))
                                    : (NW'(dm_reg) << FRAC_BITS);
    assign rem2   = {rem_reg, nlo_reg[30]};
    assign rem_ge = rem2 >= {1'b0, den_reg};
    assign dsign  = (sel_reg == DIV_K) ? g_reg[31] : dneg_reg;
    assign dres   = dsat_reg ? (dsign ? 32'sh80000000 : 32'sh7FFFFFFF)
                             : (dsign ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg}));

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a   = 32'd0;
        mul_b   = 32'd0;
        mul_neg = 1'b0;
        unique case (state_reg)
            S_DD0:
            begin
                mul_a = mag32(dx_reg);
                mul_b = mag32(dx_reg);
            end
            S_DD1:
            begin
                mul_a = mag32(dy_reg);
                mul_b = mag32(dy_reg);
            end
            S_VV0:
            begin
                mul_a = mag32(vx_reg);
                mul_b = mag32(vx_reg);
            end
            S_VV1:
            begin
                mul_a = mag32(vy_reg);
                mul_b = mag32(vy_reg);
            end
            S_P1:
            begin
                mul_a   = mag32(vx_reg);
                mul_b   = mag32(dx_reg);
                mul_neg = vx_reg[31] ^ dx_reg[31];
            end
            S_P2:
            begin
                mul_a   = mag32(vy_reg);
                mul_b   = mag32(dy_reg);
                mul_neg = vy_reg[31] ^ dy_reg[31];
            end
            S_IN2:
            begin
                mul_a = {1'b0, infl_reg};
                mul_b = {1'b0, infl_reg};
            end
            S_CR2:
            begin
                mul_a = {1'b0, crit_reg};
                mul_b = {1'b0, crit_reg};
            end
            S_H:
            begin
                mul_a   = {1'b0, w_reg};
                mul_b   = mag32(k_reg);
                mul_neg = k_reg[31];
            end
            S_T1:
            begin
                mul_a   = mag32(vx_reg);
                mul_b   = mag32(s_reg);
                mul_neg = vx_reg[31] ^ s_reg[31];
            end
            S_T2:
            begin
                mul_a   = mag32(vy_reg);
                mul_b   = mag32(s_reg);
                mul_neg = vy_reg[31] ^ s_reg[31];
            end
            S_F1:
            begin
                mul_a   = mag32(h_reg);
                mul_b   = mag32(ex_reg);
                mul_neg = h_reg[31] ^ ex_reg[31];
            end
            S_F2:
            begin
                mul_a   = mag32(h_reg);
                mul_b   = mag32(ey_reg);
                mul_neg = h_reg[31] ^ ey_reg[31];
            end
            S_G0:
            begin
                mul_a   = 32'(smag_x[47:24]);
                mul_b   = {1'b0, gain_reg};
                mul_neg = sum_x_reg[47];
            end
            S_G1:
            begin
                mul_a   = 32'(smag_x[23:0]);
                mul_b   = {1'b0, gain_reg};
                mul_neg = sum_x_reg[47];
            end
            S_G2:
            begin
                mul_a   = 32'(smag_y[47:24]);
                mul_b   = {1'b0, gain_reg};
                mul_neg = sum_y_reg[47];
            end
            S_G3:
            begin
                mul_a   = 32'(smag_y[23:0]);
                mul_b   = {1'b0, gain_reg};
                mul_neg = sum_y_reg[47];
            end
            default:
            begin
                mul_neg = 1'b0;
            end
        endcase
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        pneg_reg <= mul_neg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    dx_reg    <= s_tdata[31:0];
                    dy_reg    <= s_tdata[63:32];
                    vx_reg    <= s_tdata[95:64];
                    vy_reg    <= s_tdata[127:96];
                    infl_reg  <= s_tdata[158:128];
                    crit_reg  <= s_tdata[189:159];
                    w_reg     <= s_tdata[220:190];
                    tx_reg    <= s_tdata[252:221];
                    ty_reg    <= s_tdata[284:253];
                    valid_reg <= s_tuser;
                    last_reg  <= s_tlast;
                end
            end
            S_DD1: dd_reg <= prod_reg;
            S_VV0: dd_reg <= dd_reg + prod_reg;
            S_VV1: vv_reg <= prod_reg;
            S_P1:  vv_reg <= vv_reg + prod_reg;
            S_P2:  p1_reg <= pval;
            S_IN2:
            begin
                // Positive overflow of the dot product clamps to the int64 maximum
                dneg_reg <= dsum[WIDE_W-1];
                if (dsum[WIDE_W-1])
                    dm_reg <= 63'(-dsum);
                else if (dsum > $signed({19'd0, 63'h7FFFFFFFFFFFFFFF}))
                    dm_reg <= 63'h7FFFFFFFFFFFFFFF;
                else
                    dm_reg <= 63'(dsum);
            end
            S_CR2: inside_reg <= valid_reg && (dd_reg < prod_reg);
            S_DEC: critical_reg <= inside_reg && (dd_reg < prod_reg) && (w_reg > WMIN);
            S_DLD:
            begin
                dhi_reg <= num[NW-1:31];
                nlo_reg <= num[30:0];
                den_reg <= (sel_reg == DIV_S) ? vv_reg : dd_reg;
            end
            S_DCHK:
            begin
                // Quotient of 2^31 or more saturates
                dsat_reg <= 64'(dhi_reg) >= den_reg;
                rem_reg  <= 64'(dhi_reg);
                quo_reg  <= 31'd0;
            end
            S_DRUN:
            begin
                rem_reg <= rem_ge ? 64'(rem2 - {1'b0, den_reg}) : rem2[63:0];
                quo_reg <= {quo_reg[29:0], rem_ge};
                nlo_reg <= {nlo_reg[29:0], 1'b0};
            end
            S_DEND:
            begin
                case (sel_reg)
                    DIV_S:   s_reg <= dres;
                    DIV_G:   g_reg <= dres;
                    default: k_reg <= dres;
                endcase
            end
            S_T1:  h_reg  <= sat32(psh);
            S_T2:  ex_reg <= sat32(psh - WIDE_W'(dx_reg));
            S_F1:  ey_reg <= sat32(psh - WIDE_W'(dy_reg));
            S_G1:  gh_reg <= prod_reg;
            S_G2:  fx_reg <= sat32(WIDE_W'(tx_reg) + gsig);
            S_G3:  gh_reg <= prod_reg;
            S_G4:  fy_reg <= sat32(WIDE_W'(ty_reg) + gsig);
            default:
            begin
                gh_reg <= gh_reg;
            end
        endcase
    end

    // Sequencer, running sum, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= DIV_S;
            cnt_reg   <= 5'd0;
            ov_reg    <= 1'b0;
            odata_reg <= 128'd0;
            ouser_reg <= 1'b0;
            olast_reg <= 1'b0;
            sum_x_reg <= 48'sd0;
            sum_y_reg <= 48'sd0;
            gain_reg  <= GAIN_RST;
        end
        else
        begin
            if (cfg_wr)
                gain_reg <= pwdata[30:0];
            // Drop the result once taken; the load cycle handles its own drain
            if (m_tvalid && m_tready && (state_reg != S_DONE))
                ov_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:  if (s_tvalid) state_reg <= S_DD0;
                S_DD0:   state_reg <= S_DD1;
                S_DD1:   state_reg <= S_VV0;
                S_VV0:   state_reg <= S_VV1;
                S_VV1:   state_reg <= S_P1;
                S_P1:    state_reg <= S_P2;
                S_P2:    state_reg <= S_IN2;
                S_IN2:   state_reg <= S_CR2;
                S_CR2:   state_reg <= S_DEC;
                S_DEC:
                begin
                    sel_reg <= DIV_S;
                    if (contrib)
                        state_reg <= S_DLD;
                    else if (last_reg)
                        state_reg <= S_G0;
                    else
                        state_reg <= S_DONE;
                end
                S_DLD:   state_reg <= S_DCHK;
                S_DCHK:
                begin
                    cnt_reg   <= 5'd30;
                    state_reg <= S_DRUN;
                end
                S_DRUN:
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                        state_reg <= S_DEND;
                end
                S_DEND:
                begin
                    case (sel_reg)
                        DIV_S:
                        begin
                            sel_reg   <= DIV_G;
                            state_reg <= S_DLD;
                        end
                        DIV_G:
                        begin
                            sel_reg   <= DIV_K;
                            state_reg <= S_DLD;
                        end
                        default: state_reg <= S_H;
                    endcase
                end
                S_H:     state_reg <= S_T1;
                S_T1:    state_reg <= S_T2;
                S_T2:    state_reg <= S_F1;
                S_F1:    state_reg <= S_F2;
                S_F2:
                begin
                    sum_x_reg <= sat48(WIDE_W'(sum_x_reg) + WIDE_W'(sat32(psh)));
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    sum_y_reg <= sat48(WIDE_W'(sum_y_reg) + WIDE_W'(sat32(psh)));
                    state_reg <= last_reg ? S_G0 : S_DONE;
                end
                S_G0:    state_reg <= S_G1;
                S_G1:    state_reg <= S_G2;
                S_G2:    state_reg <= S_G3;
                S_G3:    state_reg <= S_G4;
                S_G4:    state_reg <= S_DONE;
                S_DONE:
                begin
                    // Hold until the output register is free
                    if (!ov_reg || m_tready)
                    begin
                        ov_reg    <= 1'b1;
                        ouser_reg <= critical_reg;
                        olast_reg <= last_reg;
                        odata_reg <= {last_reg ? fy_reg : 32'sd0,
                                      last_reg ? fx_reg : 32'sd0,
                                      critical_reg ? dy_reg : 32'sd0,
                                      critical_reg ? dx_reg : 32'sd0};
                        if (last_reg)
                        begin
                            sum_x_reg <= 48'sd0;
                            sum_y_reg <= 48'sd0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/cfaf_chk.sv]
// Port-level checker for the circular field avoidance block, bound to the top level.
module cfaf_chk
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tuser,
    input logic         m_tlast,
    input logic         pready
);
    import cfaf_pkg::*;

    // A new transaction is never taken in the cycle right after one was taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Force fields are zero except on the last result
    a_force_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[127:64] == 64'd0)
        else $error("force given on a non-last result");

    // Echoed vector is zero unless critical
    a_crit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[63:0] == 64'd0)
        else $error("vector echoed for a non-critical obstacle");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind circular_field_avoid_force cfaf_chk u_cfaf_chk (.*);

[tb/tb_circular_field_avoid_force.sv]
// Self-checking testbench for the circular field obstacle avoidance force block.
module tb_circular_field_avoid_force;
    import cfaf_pkg::*;

    localparam int FB           = 16;
    localparam int WEIGHT_FLOOR = (1 << FB) / 100000;
    localparam int STALL_MAX    = 11;
    localparam int WATCHDOG_MAX = 4000;
    localparam int DRAIN_CYCLES = 200;

    // APB byte addresses
    localparam logic [2:0] ADDR_FORCE_GAIN = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;

    localparam logic [30:0] GAIN_ONE = 31'h0001_0000;
    localparam logic [30:0] GAIN_MAX = 31'h7FFF_FFFF;

    typedef logic signed [127:0] wide_t;
    localparam wide_t CAP40 = wide_t'(1) <<< 40;

    typedef struct {
        bit                 valid;
        logic signed [31:0] dx, dy, vx, vy, tx, ty;
        logic [30:0]        infl, critd, w;
        bit                 last;
    } obstacle_t;

    typedef struct {
        bit          crit;
        logic [31:0] cx, cy;
        bit          fvalid;
        logic [31:0] fx, fy;
    } force_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // vec_x, vec_y, vel_x, vel_y, influence_dist, critical_dist, weight, target_x, target_y, zero
    logic [287:0] s_tdata;
    // obstacle_valid
    logic         s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    // crit_x, crit_y, force_x, force_y
    logic [127:0] m_tdata;
    // is_critical
    logic         m_tuser;
    logic         m_tlast;
    logic         psel, penable, pwrite, pready;
    logic [2:0]   paddr;
    logic [31:0]  pwdata, prdata;

    circular_field_avoid_force u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: running force sums and the gain register copy
    wide_t         acc_x, acc_y;
    logic [30:0]   gain_copy;
    force_result_t expected_results[$];
    int            errors;
    bit            burst;
    int            quiet_cycles;

    obstacle_t     dir_items[$];
    bit            dir_typed[$];
    force_result_t dir_exp[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- arithmetic
    function automatic wide_t absw(wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    // Clip a magnitude at 2^40, then apply the sign
    function automatic wide_t signed_cap(bit neg, wide_t m);
        if (m > CAP40)
            m = CAP40;
        return neg ? -m : m;
    endfunction

    function automatic wide_t clip32(wide_t v);
        if (v > 128'sd2147483647)
            return 128'sd2147483647;
        if (v < -128'sd2147483648)
            return -128'sd2147483648;
        return v;
    endfunction

    function automatic wide_t clip48(wide_t v);
        if (v > 128'sd140737488355327)
            return 128'sd140737488355327;
        if (v < -128'sd140737488355328)
            return -128'sd140737488355328;
        return v;
    endfunction

    function automatic wide_t qmul(wide_t a, wide_t b);
        return signed_cap((a < 0) != (b < 0), (absw(a) * absw(b)) >> FB);
    endfunction

    // floor(n * 2^fb / d) for non-negative n and positive d, clipped at 2^40
    function automatic wide_t qdiv(wide_t n, wide_t d, int fb);
        return signed_cap(1'b0, (n <<< fb) / d);
    endfunction

    // Work out the result of one obstacle and advance the running sums
    function automatic force_result_t compute_avoidance(obstacle_t o);
        force_result_t r;
        wide_t dx, dy, vx, vy, dd, vv, dot, dm, s, g, k, h, ex, ey;
        bit    neg;
        dx = o.dx; dy = o.dy; vx = o.vx; vy = o.vy;
        dd = dx * dx + dy * dy;
        vv = vx * vx + vy * vy;
        r = '{default: '0};
        if (o.valid && dd < wide_t'(o.infl) * wide_t'(o.infl))
        begin
            r.crit = (dd < wide_t'(o.critd) * wide_t'(o.critd)) && (o.w > WEIGHT_FLOOR);
            if (dd != 0 && vv != 0)
            begin
                dot = vx * dx + vy * dy;
                if (dot > 128'sh7FFF_FFFF_FFFF_FFFF)
                    dot = 128'sh7FFF_FFFF_FFFF_FFFF;
                neg = dot < 0;
                dm  = absw(dot);
                s   = clip32(signed_cap(neg, qdiv(dm, vv, FB)));
                g   = clip32(signed_cap(neg, qdiv(dm, dd, FB)));
                k   = clip32(signed_cap(g < 0, qdiv(absw(g), dd, 2 * FB)));
                h   = clip32(qmul(wide_t'(o.w), k));
                ex  = clip32(qmul(vx, s) - dx);
                ey  = clip32(qmul(vy, s) - dy);
                acc_x = clip48(acc_x + clip32(qmul(h, ex)));
                acc_y = clip48(acc_y + clip32(qmul(h, ey)));
            end
        end
        if (r.crit)
        begin
            r.cx = o.dx;
            r.cy = o.dy;
        end
        r.fvalid = o.last;
        if (o.last)
        begin
            r.fx  = 32'(clip32(wide_t'(o.tx) + qmul(acc_x, wide_t'(gain_copy))));
            r.fy  = 32'(clip32(wide_t'(o.ty) + qmul(acc_y, wide_t'(gain_copy))));
            acc_x = 0;
            acc_y = 0;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus
    // Random signed value spanning the given number of bits
    function automatic logic signed [31:0] rnd_signed(int bits);
        logic signed [31:0] v;
        v = $urandom;
        return v >>> (32 - bits);
    endfunction

    function automatic int rnd_bits();
        int pick;
        pick = $urandom_range(0, 4);
        return (pick == 0) ? 10 : (pick == 1) ? 18 : (pick == 2) ? 22 : (pick == 3) ? 26 : 32;
    endfunction

    function automatic obstacle_t rand_obstacle(bit last);
        obstacle_t o;
        int        db, vb;
        db = rnd_bits();
        vb = rnd_bits();
        o.valid = $urandom_range(0, 9) != 0;
        o.dx = rnd_signed(db);
        o.dy = rnd_signed(db);
        o.vx = rnd_signed(vb);
        o.vy = rnd_signed(vb);
        // drop d or v to zero now and then
        if ($urandom_range(0, 15) == 0)
        begin
            o.dx = '0;
            o.dy = '0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            o.vx = '0;
            o.vy = '0;
        end
        o.infl  = ($urandom_range(0, 3) == 0) ? 31'($urandom) : GAIN_MAX;
        o.critd = ($urandom_range(0, 1) == 0) ? 31'($urandom) : 31'($urandom >> $urandom_range(1, 20));
        case ($urandom_range(0, 3))
            0:       o.w = '0;
            1:       o.w = 31'($urandom);
            default: o.w = 31'($urandom_range(0, 32'h0004_0000));
        endcase
        o.tx   = rnd_signed(rnd_bits());
        o.ty   = rnd_signed(rnd_bits());
        o.last = last;
        return o;
    endfunction

    function automatic obstacle_t mk(bit valid, int dx, int dy, int vx, int vy,
                                     logic [30:0] infl, logic [30:0] critd, logic [30:0] w,
                                     int tx, int ty, bit last);
        obstacle_t o;
        o = '{valid, dx, dy, vx, vy, tx, ty, infl, critd, w, last};
        return o;
    endfunction

    task automatic add_row(obstacle_t o, bit typed, force_result_t e);
        dir_items.push_back(o);
        dir_typed.push_back(typed);
        dir_exp.push_back(e);
    endtask

    // Present one obstacle after a random gap, or none in burst mode, and hold it until accepted
    task automatic send_obstacle(obstacle_t o, bit typed, force_result_t e);
        int gap;
        gap = burst ? 0 : $urandom_range(0, STALL_MAX);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, o.ty, o.tx, o.w, o.critd, o.infl, o.vy, o.vx, o.dy, o.dx};
        s_tuser  <= o.valid;
        s_tlast  <= o.last;
        do
            @(posedge clk);
        while (!s_tready);
        e = typed ? e : compute_avoidance(o);
        if (typed)
            void'(compute_avoidance(o));
        expected_results.push_back(e);
    endtask

    task automatic release_stream();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Wait until every result has come back, then write a register over APB
    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        wait (expected_results.size() == 0);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_FORCE_GAIN)
            gain_copy = data[30:0];
    endtask

    // Random lists of obstacles, each closed by a transaction marked last
    task automatic run_lists(int count);
        int n, len;
        force_result_t none;
        none = '{default: '0};
        n = 0;
        while (n < count)
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_obstacle(rand_obstacle(i == len - 1), 1'b0, none);
            n += len;
        end
        release_stream();
    endtask

    // ---------------------------------------------------------------- response side
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = burst ? 0 : $urandom_range(0, STALL_MAX);
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Compare every result transaction with the oldest expectation
    always @(posedge clk)
    begin
        force_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result crit=%0b data=%h force_valid=%0b",
                         $time, m_tuser, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (m_tuser !== e.crit || m_tdata[31:0] !== e.cx || m_tdata[63:32] !== e.cy ||
                    m_tlast !== e.fvalid || m_tdata[95:64] !== e.fx ||
                    m_tdata[127:96] !== e.fy)
                begin
                    $display("%0t: mismatch expected crit=%0b cx=%h cy=%h fv=%0b fx=%h fy=%h",
                             $time, e.crit, e.cx, e.cy, e.fvalid, e.fx, e.fy);
                    $display("%0t:          actual   crit=%0b cx=%h cy=%h fv=%0b fx=%h fy=%h",
                             $time, m_tuser, m_tdata[31:0], m_tdata[63:32], m_tlast,
                             m_tdata[95:64], m_tdata[127:96]);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_MAX)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence
    initial
    begin
        force_result_t e, none;
        logic [30:0]   phase_gain [6];
        errors       = 0;
        quiet_cycles = 0;
        burst        = 1'b0;
        acc_x        = 0;
        acc_y        = 0;
        gain_copy    = GAIN_ONE;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        s_tlast      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        none         = '{default: '0};

        // empty list straight after reset: force is the target
        e = '{1'b0, 32'h0, 32'h0, 1'b1, 32'h0005_0000, 32'hFFFD_0000};
        add_row(mk(0, 1, 2, 3, 4, GAIN_MAX, GAIN_MAX, GAIN_MAX, 32'h0005_0000, 32'hFFFD_0000, 1),
                1'b1, e);
        // invalid obstacle with every field at its top
        add_row(mk(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, GAIN_MAX,
                   GAIN_MAX, GAIN_MAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0), 1'b1, none);
        // zero distance: critical, nothing added
        e = '{1'b1, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0};
        add_row(mk(1, 0, 0, 32'h0001_0000, 32'h0002_0000, 31'd1, 31'd1, 31'd1, 0, 0, 0), 1'b1, e);
        // zero velocity: critical, d echoed, nothing added
        e = '{1'b1, 32'h0001_0000, 32'hFFFF_0000, 1'b0, 32'h0, 32'h0};
        add_row(mk(1, 32'h0001_0000, 32'hFFFF_0000, 0, 0, GAIN_MAX, GAIN_MAX, GAIN_ONE, 0, 0, 0),
                1'b1, e);
        // close with extreme targets; the sum is still empty
        e = '{1'b0, 32'h0, 32'h0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000};
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1), 1'b1, e);
        // zero weight is never critical
        add_row(mk(1, 32'h0000_8000, 0, 32'h0001_0000, 0, GAIN_MAX, GAIN_MAX, 0, 0, 0, 0),
                1'b0, none);
        // outside the influence distance
        add_row(mk(1, 32'h000A_0000, 0, 32'h0001_0000, 0, 31'h0005_0000, GAIN_MAX, GAIN_ONE,
                   0, 0, 0), 1'b0, none);
        // exactly on the influence and critical distances
        add_row(mk(1, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 0, 31'h0005_0000,
                   31'h0005_0000, GAIN_ONE, 0, 0, 0), 1'b0, none);
        add_row(mk(1, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, GAIN_MAX,
                   31'h0003_0000, GAIN_ONE, 32'h0001_0000, 32'h0002_0000, 1), 1'b0, none);
        // dot product saturates at the int64 top
        add_row(mk(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, GAIN_MAX,
                   GAIN_MAX, GAIN_MAX, 0, 0, 0), 1'b0, none);
        add_row(mk(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, GAIN_MAX,
                   GAIN_MAX, GAIN_MAX, 0, 0, 1), 1'b0, none);
        // tiny distance, large velocity: quotients clip
        add_row(mk(1, 1, 0, 32'h7FFF_FFFF, 32'h0000_0001, GAIN_MAX, GAIN_MAX, GAIN_MAX, 0, 0, 0),
                1'b0, none);
        add_row(mk(1, 0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, GAIN_MAX, GAIN_MAX,
                   GAIN_MAX, 0, 0, 0), 1'b0, none);
        add_row(mk(1, 2, 3, 32'hFFFF_FFF0, 32'h0000_0020, GAIN_MAX, 31'd2, GAIN_MAX, 0, 0, 0),
                1'b0, none);
        add_row(mk(1, 32'h0000_0100, 32'hFFFF_FF00, 32'h0100_0000, 32'h0080_0000, GAIN_MAX,
                   GAIN_MAX, GAIN_MAX, 32'h7FFF_FFFF, 32'h8000_0000, 1), 1'b0, none);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < dir_items.size(); i++)
            send_obstacle(dir_items[i], dir_typed[i], dir_exp[i]);
        release_stream();

        // Gain sweep: extremes first, then random settings; odd phases run without idling
        phase_gain = '{GAIN_ONE, 31'd0, GAIN_MAX, 31'd1, 31'($urandom), 31'($urandom >> 12)};
        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
                apb_write(ADDR_FORCE_GAIN, {1'b0, phase_gain[p]});
            if (p == 2)
                apb_write(ADDR_UNMAPPED, $urandom);
            burst = p[0];
            run_lists(100);
        end

        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
